@@ hw/rtl/idwm_pkg.sv @@
// idwm_pkg: shared types and constants of the identifier window match table
// holds the word structs, the table entry layout, action and register codes
// no dependencies
package idwm_pkg;

  // sizes
  localparam int ENTRIES_DEF = 128;
  localparam int ID_W        = 32;
  localparam int TIME_W      = 32;
  localparam int WIN_W       = 16;
  localparam int SLOT_W      = 7;
  localparam int ACT_W       = 2;
  localparam int CFG_IDX_W   = 2;

  // input opcodes
  localparam logic OP_ANNOUNCE = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  // result actions
  localparam logic [ACT_W-1:0] ACT_SOON    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_OPEN    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REFRESH = 2'd2;
  localparam logic [ACT_W-1:0] ACT_INSERT  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_BEGIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_END   = 2'd1;

  // reset values
  localparam logic [WIN_W-1:0]  WIN_BEGIN_RST = 16'd5;
  localparam logic [WIN_W-1:0]  WIN_END_RST   = 16'd10;
  localparam logic [TIME_W-1:0] NOW_RST       = 32'd1;

  // input word
  typedef struct packed {
    logic            opcode;
    logic [ID_W-1:0] announced_id;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   result_id;
  } out_word_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // scan unit control
  typedef struct packed {
    logic clear;   // new search starts
    logic sample;  // read data valid this cycle
  } scan_ctl_t;

endpackage

@@ hw/rtl/idwm_ram.sv @@
// idwm_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module idwm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/idwm_scan.sv @@
// idwm_scan: accumulates first identifier match and oldest entry over a table scan
// depends on idwm_pkg
module idwm_scan #(
  parameter int ENTRIES = idwm_pkg::ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  idwm_pkg::scan_ctl_t            ctl,
  input  logic [$clog2(ENTRIES)-1:0]     rd_idx,
  input  idwm_pkg::entry_t               rd_entry,
  input  logic [idwm_pkg::ID_W-1:0]      key,
  output logic                           found,
  output logic [$clog2(ENTRIES)-1:0]     match_idx,
  output logic [idwm_pkg::TIME_W-1:0]    match_stamp,
  output logic [$clog2(ENTRIES)-1:0]     min_idx
);

  localparam int AW = $clog2(ENTRIES);

  logic                          found_r, found_nxt;
  logic [AW-1:0]                 match_idx_r, match_idx_nxt;
  logic [idwm_pkg::TIME_W-1:0]   match_stamp_r, match_stamp_nxt;
  logic [AW-1:0]                 min_idx_r, min_idx_nxt;
  logic [idwm_pkg::TIME_W-1:0]   min_stamp_r, min_stamp_nxt;

  // first match wins, strict compare keeps lowest index on ties
  always_comb begin
    found_nxt       = found_r;
    match_idx_nxt   = match_idx_r;
    match_stamp_nxt = match_stamp_r;
    min_idx_nxt     = min_idx_r;
    min_stamp_nxt   = min_stamp_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (ctl.sample) begin
      if (!found_r && rd_entry.id == key) begin
        found_nxt       = 1'b1;
        match_idx_nxt   = rd_idx;
        match_stamp_nxt = rd_entry.stamp;
      end
      if (rd_idx == '0 || rd_entry.stamp < min_stamp_r) begin
        min_idx_nxt   = rd_idx;
        min_stamp_nxt = rd_entry.stamp;
      end
    end
  end

  // match flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  // accumulated indexes and stamps
  always_ff @(posedge clk) begin
    match_idx_r   <= match_idx_nxt;
    match_stamp_r <= match_stamp_nxt;
    min_idx_r     <= min_idx_nxt;
    min_stamp_r   <= min_stamp_nxt;
  end

  assign found       = found_r;
  assign match_idx   = match_idx_r;
  assign match_stamp = match_stamp_r;
  assign min_idx     = min_idx_r;

endmodule

@@ hw/rtl/id_window_match_table_core.sv @@
// id_window_match_table_core: top level of the identifier window match table
// depends on idwm_pkg, idwm_ram, idwm_scan
//
// The table of ENTRIES identifier and timestamp pairs lives in one ram of
// 64-bit entries. After reset a clearing pass writes zero to every entry,
// during which no input word is accepted (configuration writes are). A tick
// word advances the time counter. An announcement word reads the whole
// table through the single ram read port, one entry per cycle, looking for
// the first identifier match and the oldest entry at once, then decides
// and writes back at most one entry before the next word is accepted.
// The result sits in an output register, so a new word is taken while it
// waits; the decide step stalls only if the previous result is still held.
module id_window_match_table_core #(
  parameter int ENTRIES = idwm_pkg::ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  idwm_pkg::in_word_t                 in_word,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output idwm_pkg::out_word_t                out_word,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [idwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [idwm_pkg::WIN_W-1:0]         cfg_data
);

  localparam int AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_DECIDE = 5'b10000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [AW-1:0]                  cnt_r, cnt_nxt;
  logic [idwm_pkg::TIME_W-1:0]    now_r, now_nxt;
  logic [idwm_pkg::WIN_W-1:0]     win_begin_r, win_end_r;
  logic [idwm_pkg::ID_W-1:0]      key_r;
  logic                           rd_vld_r;
  logic [AW-1:0]                  rd_idx_r;
  logic                           out_valid_r, out_valid_nxt;
  idwm_pkg::out_word_t            out_r;

  logic                           in_acc, out_free, out_load;
  logic                           ram_we, ram_re;
  logic [AW-1:0]                  ram_waddr;
  idwm_pkg::entry_t               ram_wdata, ram_rdata;

  idwm_pkg::scan_ctl_t            scan_ctl;
  logic                           found;
  logic [AW-1:0]                  match_idx, min_idx;
  logic [idwm_pkg::TIME_W-1:0]    match_stamp;

  logic [idwm_pkg::TIME_W-1:0]    win_lo, win_hi;
  logic [idwm_pkg::ACT_W-1:0]     dec_act;
  logic                           dec_we;
  logic [AW-1:0]                  dec_idx;
  logic [idwm_pkg::TIME_W-1:0]    dec_stamp;

  // handshakes
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // table memory
  idwm_ram #(
    .WIDTH (idwm_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt_r),
    .rdata (ram_rdata)
  );

  // match and oldest entry search
  assign scan_ctl = '{
    clear:  in_acc && (in_word.opcode == idwm_pkg::OP_ANNOUNCE),
    sample: rd_vld_r
  };

  idwm_scan #(
    .ENTRIES (ENTRIES)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (scan_ctl),
    .rd_idx      (rd_idx_r),
    .rd_entry    (ram_rdata),
    .key         (key_r),
    .found       (found),
    .match_idx   (match_idx),
    .match_stamp (match_stamp),
    .min_idx     (min_idx)
  );

  // window check, all differences wrap modulo 2^32
  assign win_lo = now_r - idwm_pkg::TIME_W'(win_end_r);
  assign win_hi = now_r - idwm_pkg::TIME_W'(win_begin_r);

  always_comb begin
    dec_idx   = match_idx;
    dec_stamp = now_r;
    dec_we    = 1'b0;
    dec_act   = idwm_pkg::ACT_SOON;
    if (!found) begin
      dec_idx = min_idx;
      dec_we  = 1'b1;
      dec_act = idwm_pkg::ACT_INSERT;
    end else if (win_lo <= match_stamp && match_stamp <= win_hi) begin
      dec_stamp = '0;
      dec_we    = 1'b1;
      dec_act   = idwm_pkg::ACT_OPEN;
    end else if (match_stamp < win_lo) begin
      dec_we  = 1'b1;
      dec_act = idwm_pkg::ACT_REFRESH;
    end
  end

  // sequencer: clear, scan, drain the read pipe, decide and write back
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    now_nxt         = now_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_waddr       = cnt_r;
    ram_wdata       = '0;
    out_load        = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_word.opcode == idwm_pkg::OP_TICK) begin
            now_nxt = now_r + idwm_pkg::TIME_W'(1);
          end else begin
            cnt_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ram_re = 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        // write back happens here only, the next scan starts later
        if (out_free) begin
          out_load        = 1'b1;
          ram_we          = dec_we;
          ram_waddr       = dec_idx;
          ram_wdata.id    = key_r;
          ram_wdata.stamp = dec_stamp;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        cnt_nxt   = '0;
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      now_r       <= idwm_pkg::NOW_RST;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      now_r       <= now_nxt;
      rd_vld_r    <= ram_re;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_begin_r <= idwm_pkg::WIN_BEGIN_RST;
      win_end_r   <= idwm_pkg::WIN_END_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        idwm_pkg::CFG_WIN_BEGIN: win_begin_r <= cfg_data;
        idwm_pkg::CFG_WIN_END:   win_end_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;
    if (scan_ctl.clear) begin
      key_r <= in_word.announced_id;
    end
    if (out_load) begin
      out_r.action    <= dec_act;
      out_r.slot      <= idwm_pkg::SLOT_W'(dec_idx);
      out_r.result_id <= key_r;
    end
  end

endmodule

@@ hw/rtl/idwm_chk.sv @@
// idwm_chk: port level checks of the identifier window match table, with bind
// depends on idwm_pkg and id_window_match_table_core
module idwm_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input idwm_pkg::in_word_t   in_word,
  input logic                 out_valid,
  input logic                 out_ready,
  input idwm_pkg::out_word_t  out_word
);

  // a held result word stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("result word dropped or changed while stalled");

  // an accepted announcement blocks the input while the table is searched
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_word.opcode == idwm_pkg::OP_ANNOUNCE) |=> !in_ready)
    else $error("input taken during table search");

  // a tick never produces a result word
  a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_word.opcode == idwm_pkg::OP_TICK && !out_valid)
      |=> !out_valid)
    else $error("result word after a tick");

  // a new result only appears once the search has ended
  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result word without a finished search");

endmodule

bind id_window_match_table_core idwm_chk u_idwm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
